// ===== hw/rtl/i2cbs_pkg.sv =====
`default_nettype none

package i2cbs_pkg;

  // Command codes, same values as the opcode field.
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  // Data bits per byte; the slot after them is the ACK slot.
  localparam int unsigned ByteBits = 8;
  localparam int unsigned BitCntW  = $clog2(ByteBits + 1);

  localparam logic [BitCntW-1:0] AckSlot = BitCntW'(ByteBits);

  // Phase numbers inside one slot.
  localparam logic [1:0] PhSet     = 2'd0;
  localparam logic [1:0] PhRise    = 2'd1;
  localparam logic [1:0] PhSample  = 2'd2;
  localparam logic [1:0] PhFall    = 2'd3;
  localparam logic [1:0] PhWrFall  = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/i2c_master_bit_sequencer_top.sv =====
// A result is registered and appears in the cycle after its input transaction is accepted.
// Throughput: one input transaction per cycle while in_stall is low; each input is one line step.
// Input stall follows output stall only while a result is held unread.
// Reset (rst, synchronous, active high): sequencer idle, both lines
// released, shift byte, ACK choice and NAK flag cleared, no result held.
`default_nettype none

module i2c_master_bit_sequencer_top (
  input  wire logic       clk,
  input  wire logic       rst,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] opcode,
  input  wire logic [7:0] write_data,
  input  wire logic       send_ack,
  input  wire logic       sda_level,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            sda_low,
  output logic            scl_low,
  output logic            busy_res,
  output logic            done_res,
  output logic            nak,
  output logic [7:0]      read_data
);

  // Sequencer state. The step number of a byte command is kept as a
  // slot counter (one slot per bit, ACK slot last) and a phase within
  // the slot, so no divide by three is needed.
  i2cbs_pkg::cmd_t                         cmd, cmd_next;
  logic [1:0]                              ph, ph_next;
  logic [i2cbs_pkg::BitCntW-1:0]           bitcnt, bitcnt_next;
  logic [7:0]                              shift_byte, shift_byte_next;
  logic                                    ack_choice, ack_choice_next;
  logic                                    sda_drive, sda_drive_next;
  logic                                    scl_drive, scl_drive_next;
  logic                                    nak_flag, nak_flag_next;

  // Working copies after a possible command load in this tick.
  i2cbs_pkg::cmd_t                         cmd_c;
  logic [1:0]                              ph_c;
  logic [i2cbs_pkg::BitCntW-1:0]           bitcnt_c;
  logic [7:0]                              shift_c;
  logic                                    ack_c;
  logic                                    nak_c;

  logic                                    ack_slot;
  logic                                    rd_slot;
  logic                                    wbit;
  logic                                    slot_end;
  logic                                    busy_v;
  logic                                    done_v;
  logic                                    nak_v;
  logic [7:0]                              rdata_v;

  logic                                    accept;

  // The result register frees up in the same cycle its transaction is taken,
  // so the input is held off only when a result waits and is stalled.
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    // Load a new command only when idle; unused opcodes are ignored.
    cmd_c    = cmd;
    ph_c     = ph;
    bitcnt_c = bitcnt;
    shift_c  = shift_byte;
    ack_c    = ack_choice;
    nak_c    = nak_flag;
    if (cmd == i2cbs_pkg::CMD_NONE &&
        (opcode inside {[i2cbs_pkg::CMD_START:i2cbs_pkg::CMD_READ]})) begin
      cmd_c    = i2cbs_pkg::cmd_t'(opcode);
      ph_c     = '0;
      bitcnt_c = '0;
      nak_c    = 1'b0;
      ack_c    = send_ack;
      shift_c  = (opcode == i2cbs_pkg::CMD_WRITE) ? write_data : 8'd0;
    end

    cmd_next        = cmd_c;
    ph_next         = ph_c;
    bitcnt_next     = bitcnt_c;
    shift_byte_next = shift_c;
    ack_choice_next = ack_c;
    nak_flag_next   = nak_c;
    sda_drive_next  = sda_drive;
    scl_drive_next  = scl_drive;

    ack_slot = (bitcnt_c == i2cbs_pkg::AckSlot);
    // Write byte reads only in its ACK slot; read byte reads everywhere else.
    rd_slot  = (cmd_c == i2cbs_pkg::CMD_WRITE) ? ack_slot : ~ack_slot;
    // Bit for a write slot: data MSB, or the host ACK (low) / NAK (released).
    wbit     = (cmd_c == i2cbs_pkg::CMD_WRITE) ? shift_c[7] : ~ack_c;
    slot_end = 1'b0;
    done_v   = 1'b0;
    busy_v   = (cmd_c != i2cbs_pkg::CMD_NONE);

    case (cmd_c)
      i2cbs_pkg::CMD_START: begin
        case (ph_c)
          i2cbs_pkg::PhSet:    sda_drive_next = 1'b0;
          i2cbs_pkg::PhRise:   scl_drive_next = 1'b0;
          i2cbs_pkg::PhSample: sda_drive_next = 1'b1;
          default:             scl_drive_next = 1'b1;
        endcase
        done_v  = (ph_c == i2cbs_pkg::PhFall);
        ph_next = ph_c + 2'd1;
      end
      i2cbs_pkg::CMD_STOP: begin
        case (ph_c)
          i2cbs_pkg::PhSet:  sda_drive_next = 1'b1;
          i2cbs_pkg::PhRise: scl_drive_next = 1'b0;
          default:           sda_drive_next = 1'b0;
        endcase
        done_v  = (ph_c == i2cbs_pkg::PhWrFall);
        ph_next = ph_c + 2'd1;
      end
      i2cbs_pkg::CMD_WRITE, i2cbs_pkg::CMD_READ: begin
        if (rd_slot) begin
          case (ph_c)
            i2cbs_pkg::PhSet:  sda_drive_next = 1'b0;
            i2cbs_pkg::PhRise: scl_drive_next = 1'b0;
            i2cbs_pkg::PhSample: begin
              if (cmd_c == i2cbs_pkg::CMD_WRITE) begin
                nak_flag_next = sda_level;
              end else begin
                shift_byte_next = {shift_c[6:0], sda_level};
              end
            end
            default: scl_drive_next = 1'b1;
          endcase
          slot_end = (ph_c == i2cbs_pkg::PhFall);
        end else begin
          case (ph_c)
            i2cbs_pkg::PhSet:  sda_drive_next = ~wbit;
            i2cbs_pkg::PhRise: scl_drive_next = 1'b0;
            default: begin
              scl_drive_next = 1'b1;
              if (cmd_c == i2cbs_pkg::CMD_WRITE) begin
                shift_byte_next = {shift_c[6:0], 1'b0};
              end
            end
          endcase
          slot_end = (ph_c == i2cbs_pkg::PhWrFall);
        end
        if (slot_end) begin
          ph_next     = '0;
          bitcnt_next = bitcnt_c + 1'b1;
          done_v      = ack_slot;
        end else begin
          ph_next = ph_c + 2'd1;
        end
      end
      default: ;
    endcase

    nak_v   = done_v & (cmd_c == i2cbs_pkg::CMD_WRITE) & nak_flag_next;
    rdata_v = (done_v && cmd_c == i2cbs_pkg::CMD_READ) ? shift_byte_next : 8'd0;

    if (done_v) begin
      cmd_next    = i2cbs_pkg::CMD_NONE;
      ph_next     = '0;
      bitcnt_next = '0;
    end
  end

  // Sequencer state advances once per accepted input transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd        <= i2cbs_pkg::CMD_NONE;
      ph         <= '0;
      bitcnt     <= '0;
      shift_byte <= '0;
      ack_choice <= 1'b0;
      sda_drive  <= 1'b0;
      scl_drive  <= 1'b0;
      nak_flag   <= 1'b0;
    end else if (accept) begin
      cmd        <= cmd_next;
      ph         <= ph_next;
      bitcnt     <= bitcnt_next;
      shift_byte <= shift_byte_next;
      ack_choice <= ack_choice_next;
      sda_drive  <= sda_drive_next;
      scl_drive  <= scl_drive_next;
      nak_flag   <= nak_flag_next;
    end
  end

  // Result register: valid is control, the fields are plain payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sda_low   <= sda_drive_next;
      scl_low   <= scl_drive_next;
      busy_res  <= busy_v;
      done_res  <= done_v;
      nak       <= nak_v;
      read_data <= rdata_v;
    end
  end

endmodule

`default_nettype wire

// ===== tb/i2c_master_bit_sequencer_top_tb.sv =====
`default_nettype none

module i2c_master_bit_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One tick's worth of line drive plus the done-time report fields.
  typedef struct packed {
    logic       sda_low;
    logic       scl_low;
    logic       busy;
    logic       done;
    logic       nak;
    logic [7:0] rdata;
  } line_tick_t;

  // Tracks the sequencer state, predicts the lines for every accepted tick
  // and compares what comes out of the result channel, oldest first.
  class i2c_line_board;
    i2cbs_pkg::cmd_t cmd;
    bit [5:0]   step;
    bit [7:0]   shifter;
    bit         ack_sel;
    bit         sda_drv;
    bit         scl_drv;
    bit         nak_seen;
    line_tick_t expected_lines[$];
    int         errors;
    int         ticks_checked;
    int         writes_done;
    int         write_naks;
    int         reads_done;
    int         frames_done;

    function new();
      cmd      = i2cbs_pkg::CMD_NONE;
      step     = '0;
      shifter  = '0;
      ack_sel  = 1'b0;
      sda_drv  = 1'b0;
      scl_drv  = 1'b0;
      nak_seen = 1'b0;
      errors   = 0;
      ticks_checked = 0;
      writes_done   = 0;
      write_naks    = 0;
      reads_done    = 0;
      frames_done   = 0;
    endfunction

    function int pending();
      return expected_lines.size();
    endfunction

    // set SDA / raise SCL / drop SCL
    function void write_slot(logic [1:0] ph, bit b);
      if (ph == i2cbs_pkg::PhSet) sda_drv = !b;
      else if (ph == i2cbs_pkg::PhRise) scl_drv = 1'b0;
      else scl_drv = 1'b1;
    endfunction

    // release SDA / raise SCL / sample / drop SCL; returns 1 on the sample
    function bit read_slot(logic [1:0] ph, bit lvl, output bit got);
      got = 1'b0;
      if (ph == i2cbs_pkg::PhSet) sda_drv = 1'b0;
      else if (ph == i2cbs_pkg::PhRise) scl_drv = 1'b0;
      else if (ph == i2cbs_pkg::PhSample) begin
        got = lvl;
        return 1'b1;
      end else scl_drv = 1'b1;
      return 1'b0;
    endfunction

    function void take_tick(logic [2:0] op, logic [7:0] wd, logic ack, logic lvl);
      line_tick_t  r;
      int unsigned last;
      bit          got;
      r = '0;
      last = 0;
      // opcodes 5..7 and anything offered while busy are dropped
      if (cmd == i2cbs_pkg::CMD_NONE && op >= i2cbs_pkg::CMD_START &&
          op <= i2cbs_pkg::CMD_READ) begin
        cmd      = i2cbs_pkg::cmd_t'(op);
        step     = '0;
        nak_seen = 1'b0;
        ack_sel  = ack;
        shifter  = (i2cbs_pkg::cmd_t'(op) == i2cbs_pkg::CMD_WRITE) ? wd : 8'h00;
      end
      if (cmd != i2cbs_pkg::CMD_NONE) begin
        case (cmd)
          i2cbs_pkg::CMD_START: begin
            last = 3;
            case (step)
              0: sda_drv = 1'b0;
              1: scl_drv = 1'b0;
              2: sda_drv = 1'b1;
              default: scl_drv = 1'b1;
            endcase
          end
          i2cbs_pkg::CMD_STOP: begin
            last = 2;
            case (step)
              0: sda_drv = 1'b1;
              1: scl_drv = 1'b0;
              default: sda_drv = 1'b0;
            endcase
          end
          i2cbs_pkg::CMD_WRITE: begin
            last = 27;
            if (step < 24) write_slot(2'(step % 3), shifter[7 - step / 3]);
            else if (read_slot(2'((step - 24) % 4), lvl, got)) nak_seen = got;
          end
          default: begin
            last = 34;
            if (step < 32) begin
              if (read_slot(2'(step % 4), lvl, got)) shifter = {shifter[6:0], got};
            end else write_slot(2'((step - 32) % 3), !ack_sel);
          end
        endcase
        r.busy = 1'b1;
        if (step >= last) begin
          r.done = 1'b1;
          if (cmd == i2cbs_pkg::CMD_WRITE) r.nak = nak_seen;
          if (cmd == i2cbs_pkg::CMD_READ) r.rdata = shifter;
          cmd  = i2cbs_pkg::CMD_NONE;
          step = '0;
        end else begin
          step = step + 1'b1;
        end
      end
      r.sda_low = sda_drv;
      r.scl_low = scl_drv;
      expected_lines.push_back(r);
    endfunction

    function void cmp_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_lines(line_tick_t got);
      line_tick_t e;
      if (expected_lines.size() == 0) begin
        $error("result transaction with nothing expected: %p", got);
        errors++;
        return;
      end
      e = expected_lines.pop_front();
      ticks_checked++;
      cmp_field("sda_low", e.sda_low, got.sda_low);
      cmp_field("scl_low", e.scl_low, got.scl_low);
      cmp_field("busy_res", e.busy, got.busy);
      cmp_field("done_res", e.done, got.done);
      cmp_field("nak", e.nak, got.nak);
      cmp_field("read_data", e.rdata, got.rdata);
      if (e.done) begin
        frames_done++;
        if (e.nak) write_naks++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] opcode;
  logic [7:0] write_data;
  logic       send_ack;
  logic       sda_level;
  logic       out_valid;
  logic       out_stall;
  logic       sda_low;
  logic       scl_low;
  logic       busy_res;
  logic       done_res;
  logic       nak;
  logic [7:0] read_data;

  i2c_master_bit_sequencer_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .write_data(write_data),
    .send_ack  (send_ack),
    .sda_level (sda_level),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sda_low   (sda_low),
    .scl_low   (scl_low),
    .busy_res  (busy_res),
    .done_res  (done_res),
    .nak       (nak),
    .read_data (read_data)
  );

  // 8 ns clock
  always #4 clk = ~clk;

  i2c_line_board board = new();

  // percent of cycles each side sits out
  int tx_idle_pct;
  int rx_idle_pct;
  // long receiver hold-off, counted down by the stall process
  int hold_cycles;
  int ticks_sent;
  int cmds_sent;

  // Receiver side: random stall, or a solid hold-off when requested.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Monitor: note the input transaction first so a same-edge result always
  // finds its expectation queued.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) board.take_tick(opcode, write_data, send_ack, sda_level);
      if (out_valid && !out_stall)
        board.check_lines({sda_low, scl_low, busy_res, done_res, nak, read_data});
    end
  end

  // Offer one tick; returns just after the edge that accepted it.
  task automatic drive_tick(logic [2:0] op, logic [7:0] wd, logic ack, logic lvl);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    write_data <= wd;
    send_ack   <= ack;
    sda_level  <= lvl;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
  endtask

  function automatic int unsigned cmd_ticks(i2cbs_pkg::cmd_t c);
    case (c)
      i2cbs_pkg::CMD_START: return 4;
      i2cbs_pkg::CMD_STOP:  return 3;
      i2cbs_pkg::CMD_WRITE: return 28;
      default:              return 35;
    endcase
  endfunction

  // Run one command to completion. The ticks after the first carry random
  // opcodes and data, which the busy sequencer must ignore. The slave side
  // answers the ACK slot with ack_lvl and the read slots with rx_byte.
  task automatic run_cmd(i2cbs_pkg::cmd_t c, logic [7:0] wd, logic ack,
                         logic [7:0] rx_byte, logic ack_lvl);
    int unsigned n;
    logic        lvl;
    n = cmd_ticks(c);
    for (int unsigned i = 0; i < n; i++) begin
      lvl = 1'($urandom_range(1));
      if (c == i2cbs_pkg::CMD_WRITE && i == 26) lvl = ack_lvl;
      if (c == i2cbs_pkg::CMD_READ && i < 32 && i % 4 == 2) lvl = rx_byte[7 - i / 4];
      if (i == 0) drive_tick(c, wd, ack, lvl);
      else drive_tick(3'($urandom_range(7)), 8'($urandom_range(255)),
                      1'($urandom_range(1)), lvl);
    end
    cmds_sent++;
    if (c == i2cbs_pkg::CMD_WRITE) board.writes_done++;
    if (c == i2cbs_pkg::CMD_READ) board.reads_done++;
  endtask

  // Idle tick: no opcode or an unused one, random payload otherwise.
  task automatic idle_tick();
    logic [2:0] op;
    op = ($urandom_range(3) == 0) ? 3'(i2cbs_pkg::CMD_NONE) : 3'($urandom_range(7, 5));
    drive_tick(op, 8'($urandom_range(255)), 1'($urandom_range(1)),
               1'($urandom_range(1)));
  endtask

  task automatic random_cmd(i2cbs_pkg::cmd_t c);
    run_cmd(c, 8'($urandom_range(255)), 1'($urandom_range(1)),
            8'($urandom_range(255)), ($urandom_range(3) == 0));
  endtask

  // Typical bus traffic: start, a few byte transfers, stop, with the
  // occasional repeated start; now and then a broken or random sequence.
  task automatic random_traffic(int unsigned tick_goal);
    int unsigned nbytes;
    while (ticks_sent < tick_goal) begin
      if ($urandom_range(99) < 85) begin
        random_cmd(i2cbs_pkg::CMD_START);
        nbytes = $urandom_range(4, 1);
        for (int unsigned k = 0; k < nbytes; k++) begin
          if ($urandom_range(1)) random_cmd(i2cbs_pkg::CMD_WRITE);
          else random_cmd(i2cbs_pkg::CMD_READ);
          if ($urandom_range(9) == 0) random_cmd(i2cbs_pkg::CMD_START);
        end
        random_cmd(i2cbs_pkg::CMD_STOP);
      end else begin
        random_cmd(i2cbs_pkg::cmd_t'($urandom_range(4, 1)));
      end
      repeat ($urandom_range(2)) idle_tick();
    end
  endtask

  // Sender stops offering until every outstanding result has been checked.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Watchdog
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    opcode      = i2cbs_pkg::CMD_NONE;
    write_data  = '0;
    send_ack    = 1'b0;
    sda_level   = 1'b0;
    tx_idle_pct = 25;
    rx_idle_pct = 70;
    hold_cycles = 0;
    ticks_sent  = 0;
    cmds_sent   = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: idle ticks with unused opcodes before anything happens, then
    // a frame covering data extremes, ACK and NAK in both directions.
    drive_tick(3'd5, 8'hFF, 1'b1, 1'b1);
    drive_tick(3'd6, 8'h00, 1'b0, 1'b0);
    drive_tick(3'd7, 8'hFF, 1'b1, 1'b1);
    drive_tick(i2cbs_pkg::CMD_NONE, 8'h00, 1'b0, 1'b0);
    run_cmd(i2cbs_pkg::CMD_START, 8'h00, 1'b0, 8'h00, 1'b0);
    run_cmd(i2cbs_pkg::CMD_WRITE, 8'hA5, 1'b0, 8'h00, 1'b0);  // slave ACKs
    run_cmd(i2cbs_pkg::CMD_WRITE, 8'hFF, 1'b1, 8'h00, 1'b1);  // slave NAKs
    run_cmd(i2cbs_pkg::CMD_WRITE, 8'h00, 1'b0, 8'h00, 1'b0);
    run_cmd(i2cbs_pkg::CMD_READ, 8'h00, 1'b1, 8'hFF, 1'b0);   // host ACK
    run_cmd(i2cbs_pkg::CMD_READ, 8'hFF, 1'b0, 8'h00, 1'b1);   // host NAK
    run_cmd(i2cbs_pkg::CMD_READ, 8'h3C, 1'b1, 8'h5A, 1'b0);
    run_cmd(i2cbs_pkg::CMD_START, 8'h00, 1'b0, 8'h00, 1'b0);  // repeated start
    run_cmd(i2cbs_pkg::CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b0);
    run_cmd(i2cbs_pkg::CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b0);   // stop with no start
    drive_tick(3'd7, 8'h00, 1'b0, 1'b1);
    drain();

    // Random phase 1: sender mostly busy, receiver mostly stalled.
    tx_idle_pct = 25;
    rx_idle_pct = 70;
    random_traffic(ticks_sent + 130);
    drain();

    // Random phase 2: the other way round.
    tx_idle_pct = 70;
    rx_idle_pct = 25;
    random_traffic(ticks_sent + 130);
    drain();

    // Random phase 3: full rate both ways, opened by a long receiver
    // hold-off so the block backs up and stalls its input.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_cycles = 80;
    random_traffic(ticks_sent + 130);

    drain();
    repeat (5) @(posedge clk);

    $display("Covered %0d line ticks, %0d commands: %0d byte writes (%0d NAKed), %0d reads",
             board.ticks_checked, cmds_sent, board.writes_done, board.write_naks,
             board.reads_done);
    $display("%0d commands reported done, %0d check errors",
             board.frames_done, board.errors);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== i2c_master_bit_sequencer_top.f =====
hw/rtl/i2cbs_pkg.sv
hw/rtl/i2c_master_bit_sequencer_top.sv
tb/i2c_master_bit_sequencer_top_tb.sv
